// ===== src/fdt_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the float-to-decimal text formatter.
// No dependencies; imported by every module of the block.
package fdt_pkg;

  localparam logic [7:0] CHAR_NONE  = 8'h00;
  localparam logic [7:0] CHAR_MINUS = 8'h2D;
  localparam logic [7:0] CHAR_DOT   = 8'h2E;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;

  localparam int FRAC_BITS = 48;
  localparam int INT_BITS  = 32;
  localparam int MAX_INT_DIGITS = 10;

  // Biased exponent at and above which the value is NaN, infinity or too large.
  localparam logic [7:0] EXP_LIMIT = 8'd158;
  // Largest legal biased exponent, used to place the significand.
  localparam logic [7:0] EXP_TOP   = 8'd157;

  // Reciprocal of ten, exact for any 32-bit dividend with a shift of 35.
  localparam logic [31:0] RECIP_TEN = 32'hCCCC_CCCD;
  localparam int          RECIP_SHIFT = 35;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,
    ST_IDIV,
    ST_SIGN,
    ST_INT,
    ST_DOT,
    ST_FRAC,
    ST_ERR
  } fdt_state_t;

  typedef enum logic {
    OP_DIV10,
    OP_MUL10
  } fdt_op_t;

  // Result of the shared digit unit.
  typedef struct packed {
    logic [3:0]           digit;
    logic [INT_BITS-1:0]  quo;
    logic [FRAC_BITS-1:0] frac;
  } fdt_dig_res_t;

  // Decoded magnitude of one float.
  typedef struct packed {
    logic                 err;
    logic                 neg;
    logic [INT_BITS-1:0]  ipart;
    logic [FRAC_BITS-1:0] fpart;
  } fdt_unpack_t;

endpackage

// ===== src/float_to_decimal_text.sv =====
`timescale 1ns / 1ps
// Top level of the float-to-decimal text formatter: sequencer, digit store, output register.
// Depends on fdt_pkg, fdt_unpack and fdt_digit_unit.

// The block takes one IEEE single-precision bit pattern and a precision per input
// transaction and returns its text as ASCII characters, one per output transaction:
// an optional '-', the integer part without leading zeros, and, for a clamped
// precision above zero, a '.' followed by that many truncated fraction digits.
// NaN, infinity or a magnitude of 2^31 or more yields a single transaction with
// character 0 and both last_char and error_flag set. Negative zero prints no sign.
// An item yields 1 to 18 characters, of which 1 to 10 are integer digits when it formats.
// One shared digit unit yields a single digit per cycle, a fraction digit only while the
// output side accepts: it divides the integer part by ten (via a reciprocal multiply) while
// integer digits are collected lowest first, and multiplies the fraction by ten as each
// fraction digit is sent.
// in_ready is high only while the sequencer is idle; an output register holds the
// current character, so the next item can be taken while the last character waits.
module float_to_decimal_text #(
  parameter int MAX_PRECISION = 6
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] in_value_bits,
  input  logic [3:0]  in_precision,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_character,
  output logic        out_last_char,
  output logic        out_error_flag
);
  import fdt_pkg::*;

  fdt_state_t state_r, state_nxt;

  logic [31:0]          val_r, val_nxt;
  logic [3:0]           prec_r, prec_nxt;
  logic                 neg_r, neg_nxt;
  logic [INT_BITS-1:0]  quo_r, quo_nxt;
  logic [FRAC_BITS-1:0] frac_r, frac_nxt;
  logic [3:0]           nd_r, nd_nxt;

  // Integer digits, lowest first.
  logic [3:0]           digs_r [MAX_INT_DIGITS];
  logic                 digs_we;
  logic [3:0]           rd_idx;

  logic                 out_valid_r, out_valid_nxt;
  logic [7:0]           out_char_r, out_char_nxt;
  logic                 out_last_r, out_last_nxt;
  logic                 out_err_r, out_err_nxt;

  logic                 slot_free;
  logic                 load;
  logic [7:0]           ld_char;
  logic                 ld_last;
  logic                 ld_err;

  fdt_unpack_t          dec;
  fdt_op_t              unit_op;
  fdt_dig_res_t         unit_res;

  fdt_unpack u_unpack (
    .value_bits (val_r),
    .dec        (dec)
  );

  fdt_digit_unit u_digit (
    .op      (unit_op),
    .quo_in  (quo_r),
    .frac_in (frac_r),
    .res     (unit_res)
  );

  assign in_ready       = (state_r == ST_IDLE);
  assign out_valid      = out_valid_r;
  assign out_character  = out_char_r;
  assign out_last_char  = out_last_r;
  assign out_error_flag = out_err_r;

  // A new character may be loaded when the output register is empty or being drained.
  assign slot_free = !out_valid_r || out_ready;
  assign rd_idx    = nd_r - 4'd1;
  assign unit_op   = (state_r == ST_IDIV) ? OP_DIV10 : OP_MUL10;

  always_comb begin
    state_nxt = state_r;
    val_nxt   = val_r;
    prec_nxt  = prec_r;
    neg_nxt   = neg_r;
    quo_nxt   = quo_r;
    frac_nxt  = frac_r;
    nd_nxt    = nd_r;
    digs_we   = 1'b0;
    load      = 1'b0;
    ld_char   = CHAR_NONE;
    ld_last   = 1'b0;
    ld_err    = 1'b0;

    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          val_nxt   = in_value_bits;
          prec_nxt  = (in_precision > 4'(MAX_PRECISION)) ? 4'(MAX_PRECISION) : in_precision;
          state_nxt = ST_DECODE;
        end
      end
      ST_DECODE: begin
        quo_nxt   = dec.ipart;
        frac_nxt  = dec.fpart;
        neg_nxt   = dec.neg;
        nd_nxt    = 4'd0;
        state_nxt = dec.err ? ST_ERR : ST_IDIV;
      end
      ST_IDIV: begin
        // Always stores at least one digit, so zero prints as a single '0'.
        digs_we = 1'b1;
        nd_nxt  = nd_r + 4'd1;
        quo_nxt = unit_res.quo;
        if (unit_res.quo == '0) begin
          state_nxt = neg_r ? ST_SIGN : ST_INT;
        end
      end
      ST_SIGN: begin
        if (slot_free) begin
          load      = 1'b1;
          ld_char   = CHAR_MINUS;
          state_nxt = ST_INT;
        end
      end
      ST_INT: begin
        if (slot_free) begin
          load    = 1'b1;
          ld_char = CHAR_ZERO + {4'd0, digs_r[rd_idx]};
          ld_last = (nd_r == 4'd1) && (prec_r == 4'd0);
          nd_nxt  = rd_idx;
          if (nd_r == 4'd1) begin
            state_nxt = (prec_r == 4'd0) ? ST_IDLE : ST_DOT;
          end
        end
      end
      ST_DOT: begin
        if (slot_free) begin
          load      = 1'b1;
          ld_char   = CHAR_DOT;
          state_nxt = ST_FRAC;
        end
      end
      ST_FRAC: begin
        if (slot_free) begin
          load     = 1'b1;
          ld_char  = CHAR_ZERO + {4'd0, unit_res.digit};
          ld_last  = (prec_r == 4'd1);
          frac_nxt = unit_res.frac;
          prec_nxt = prec_r - 4'd1;
          if (prec_r == 4'd1) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      ST_ERR: begin
        if (slot_free) begin
          load      = 1'b1;
          ld_char   = CHAR_NONE;
          ld_last   = 1'b1;
          ld_err    = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    out_valid_nxt = out_valid_r;
    out_char_nxt  = out_char_r;
    out_last_nxt  = out_last_r;
    out_err_nxt   = out_err_r;
    if (load) begin
      out_valid_nxt = 1'b1;
      out_char_nxt  = ld_char;
      out_last_nxt  = ld_last;
      out_err_nxt   = ld_err;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    val_r      <= val_nxt;
    prec_r     <= prec_nxt;
    neg_r      <= neg_nxt;
    quo_r      <= quo_nxt;
    frac_r     <= frac_nxt;
    nd_r       <= nd_nxt;
    out_char_r <= out_char_nxt;
    out_last_r <= out_last_nxt;
    out_err_r  <= out_err_nxt;
  end

  always_ff @(posedge clk) begin
    if (digs_we) begin
      digs_r[nd_r] <= unit_res.digit;
    end
  end

endmodule

// ===== src/fdt_unpack.sv =====
`timescale 1ns / 1ps
// Decodes an IEEE single-precision pattern into sign, error and 32.48 fixed point.
// Depends on fdt_pkg.
module fdt_unpack (
  input  logic [31:0]         value_bits,
  output fdt_pkg::fdt_unpack_t dec
);
  import fdt_pkg::*;

  logic [7:0]                      bexp;
  logic [7:0]                      eff_exp;
  logic [7:0]                      shamt;
  logic [23:0]                     mant;
  logic [INT_BITS+FRAC_BITS-1:0]   wide;

  always_comb begin
    bexp    = value_bits[30:23];
    mant    = {(bexp != 8'd0), value_bits[22:0]};
    eff_exp = (bexp == 8'd0) ? 8'd1 : bexp;
    // At the top exponent the significand's low bit lands on bit 55, of weight 2^7.
    shamt   = EXP_TOP - eff_exp;
    wide    = {1'b0, mant, 55'd0} >> shamt;

    dec.err   = (bexp >= EXP_LIMIT);
    dec.neg   = value_bits[31] && (value_bits[30:0] != 31'd0);
    dec.ipart = wide[INT_BITS+FRAC_BITS-1:FRAC_BITS];
    dec.fpart = wide[FRAC_BITS-1:0];
  end

endmodule

// ===== src/fdt_digit_unit.sv =====
`timescale 1ns / 1ps
// Shared digit unit: divides by ten for integer digits, multiplies by ten for fraction digits.
// Depends on fdt_pkg.
module fdt_digit_unit (
  input  fdt_pkg::fdt_op_t                  op,
  input  logic [fdt_pkg::INT_BITS-1:0]      quo_in,
  input  logic [fdt_pkg::FRAC_BITS-1:0]     frac_in,
  output fdt_pkg::fdt_dig_res_t             res
);
  import fdt_pkg::*;

  logic [2*INT_BITS-1:0]  prod;
  logic [INT_BITS-1:0]    q;
  logic [INT_BITS-1:0]    rem;
  logic [FRAC_BITS+3:0]   f10;

  always_comb begin
    prod = (2*INT_BITS)'(quo_in) * (2*INT_BITS)'(RECIP_TEN);
    q    = INT_BITS'(prod >> RECIP_SHIFT);
    rem  = quo_in - (q << 3) - (q << 1);
    f10  = {1'b0, frac_in, 3'd0} + {3'd0, frac_in, 1'b0};

    res = '0;
    case (op)
      OP_DIV10: begin
        res.digit = rem[3:0];
        res.quo   = q;
        res.frac  = frac_in;
      end
      default: begin
        res.digit = f10[FRAC_BITS+3:FRAC_BITS];
        res.quo   = quo_in;
        res.frac  = f10[FRAC_BITS-1:0];
      end
    endcase
  end

endmodule

// ===== test/float_to_decimal_text_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for float_to_decimal_text: directed table plus random floats.
// Depends on fdt_pkg and the float_to_decimal_text RTL; needs no files or arguments.
module float_to_decimal_text_tb;
  import fdt_pkg::*;

  // The block's fraction digit limit. Every precision above it is clamped to it.
  localparam int PRECISION_LIMIT = 6;
  // Biased exponent at which the significand's lowest bit has weight one (127 + 23).
  localparam int UNIT_EXP = 150;
  localparam int SIGNIFICAND_BITS = 24;
  // The longest text is a sign, ten integer digits, a point and six fraction digits.
  localparam int TEXT_CHARS = 18;
  localparam int RANDOM_ITEMS = 285;
  localparam int IDLE_PCT = 22;
  localparam int HOLD_CYCLES = 300;
  localparam int DRAIN_CYCLES = 64;
  localparam int DIR_ROWS = 25;

  // How a directed row gets its expected text.
  typedef enum logic [1:0] {
    FROM_MODEL,
    TYPED_TEXT,
    TYPED_ERROR
  } row_check_t;

  // One row of the directed table. Typed text is right-justified, zero bytes on the left.
  typedef struct packed {
    logic [31:0]             value_bits;
    logic [3:0]              precision;
    row_check_t              check;
    logic [8*TEXT_CHARS-1:0] text;
  } dir_row_t;

  // One character of output text, as the result channel carries it.
  typedef struct packed {
    logic [7:0] character;
    logic       last_char;
    logic       error_flag;
  } text_char_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [31:0] in_value_bits = '0;
  logic [3:0]  in_precision = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [7:0]  out_character;
  logic        out_last_char;
  logic        out_error_flag;

  // Characters still owed by the block, oldest first, across all items in flight.
  text_char_t pending_chars[$];
  int         fail_count = 0;
  int         in_idle_pct = IDLE_PCT;
  int         out_idle_pct = IDLE_PCT;
  bit         hold_request = 1'b0;

  // Directed rows: signed zeros, smallest and largest subnormals, the largest
  // value that still formats, every kind of error, and clamped precisions.
  dir_row_t dir_rows [DIR_ROWS] = '{
    '{32'h0000_0000, 4'd0,  TYPED_TEXT,  "0"},
    '{32'h8000_0000, 4'd3,  TYPED_TEXT,  "0.000"},
    '{32'h3F80_0000, 4'd2,  TYPED_TEXT,  "1.00"},
    '{32'hBF80_0000, 4'd0,  TYPED_TEXT,  "-1"},
    '{32'h4120_0000, 4'd0,  TYPED_TEXT,  "10"},
    '{32'h3F00_0000, 4'd1,  TYPED_TEXT,  "0.5"},
    '{32'hBE80_0000, 4'd2,  TYPED_TEXT,  "-0.25"},
    '{32'hC2C8_0000, 4'd4,  TYPED_TEXT,  "-100.0000"},
    '{32'h0000_0001, 4'd9,  TYPED_TEXT,  "0.000000"},
    '{32'h8000_0001, 4'd6,  TYPED_TEXT,  "-0.000000"},
    '{32'h4EFF_FFFF, 4'd6,  TYPED_TEXT,  "2147483520.000000"},
    '{32'hCEFF_FFFF, 4'd15, TYPED_TEXT,  "-2147483520.000000"},
    '{32'h7F80_0000, 4'd3,  TYPED_ERROR, '0},
    '{32'hFF80_0000, 4'd0,  TYPED_ERROR, '0},
    '{32'h7FC0_0000, 4'd6,  TYPED_ERROR, '0},
    '{32'hFFFF_FFFF, 4'd15, TYPED_ERROR, '0},
    '{32'h4F00_0000, 4'd2,  TYPED_ERROR, '0},
    '{32'h7F7F_FFFF, 4'd1,  TYPED_ERROR, '0},
    '{32'h4049_0FDB, 4'd7,  FROM_MODEL,  '0},
    '{32'hC049_0FDB, 4'd15, FROM_MODEL,  '0},
    '{32'h3DCC_CCCD, 4'd6,  FROM_MODEL,  '0},
    '{32'h3F7F_FFFF, 4'd6,  FROM_MODEL,  '0},
    '{32'h007F_FFFF, 4'd6,  FROM_MODEL,  '0},
    '{32'h8080_0000, 4'd5,  FROM_MODEL,  '0},
    '{32'h4B7F_FFFF, 4'd1,  FROM_MODEL,  '0}
  };

  float_to_decimal_text #(
    .MAX_PRECISION(PRECISION_LIMIT)
  ) dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_value_bits (in_value_bits),
    .in_precision  (in_precision),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_character (out_character),
    .out_last_char (out_last_char),
    .out_error_flag(out_error_flag)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Appends one item's text to the expected stream, marking its final character.
  function automatic void push_text(input logic [7:0] chars[$]);
    text_char_t tc;
    for (int k = 0; k < chars.size(); k++) begin
      tc.character  = chars[k];
      tc.last_char  = (k == chars.size() - 1);
      tc.error_flag = 1'b0;
      pending_chars.push_back(tc);
    end
  endfunction

  // Works out the text for one float. The magnitude is placed in 32.48 fixed point,
  // exactly as the block does, and then turned into digits.
  function automatic void format_value(input logic [31:0] value_bits,
                                       input logic [3:0] precision);
    int unsigned bexp;
    int unsigned shift;
    int unsigned frac_digits;
    logic [63:0] signif;
    logic [63:0] ipart;
    logic [63:0] fpart;
    logic [63:0] low;
    logic [7:0]  int_digits[$];
    logic [7:0]  chars[$];
    bexp = {24'd0, value_bits[30:23]};
    signif = {41'd0, value_bits[22:0]};
    ipart = '0;
    fpart = '0;
    low = '0;
    if (bexp >= EXP_LIMIT) begin
      pending_chars.push_back('{CHAR_NONE, 1'b1, 1'b1});
      return;
    end
    // Subnormals take the smallest normal exponent and have no hidden bit.
    if (bexp == 0) begin
      bexp = 1;
    end else begin
      signif[23] = 1'b1;
    end
    if (bexp >= UNIT_EXP) begin
      ipart = signif << (bexp - UNIT_EXP);
    end else begin
      shift = UNIT_EXP - bexp;
      if (shift < SIGNIFICAND_BITS) begin
        ipart = signif >> shift;
        low = signif & ((64'd1 << shift) - 64'd1);
      end else begin
        low = signif;
      end
      // Fraction bits below 2^-48 fall away.
      if (shift <= FRAC_BITS) begin
        fpart = low << (FRAC_BITS - shift);
      end else if (shift - FRAC_BITS < 64) begin
        fpart = low >> (shift - FRAC_BITS);
      end
    end
    // Negative zero is the one negative pattern that prints without a sign.
    if (value_bits[31] && (ipart != 0 || fpart != 0 || signif != 0)) begin
      chars.push_back(CHAR_MINUS);
    end
    do begin
      int_digits.push_front(CHAR_ZERO + 8'(ipart % 10));
      ipart = ipart / 10;
    end while (ipart != 0 && int_digits.size() < MAX_INT_DIGITS);
    foreach (int_digits[k]) begin
      chars.push_back(int_digits[k]);
    end
    frac_digits = (precision > 4'(PRECISION_LIMIT)) ? PRECISION_LIMIT : {28'd0, precision};
    if (frac_digits > 0) begin
      chars.push_back(CHAR_DOT);
      // Each multiply by ten pushes the next truncated digit above the binary point.
      for (int k = 0; k < frac_digits; k++) begin
        fpart = fpart * 10;
        chars.push_back(CHAR_ZERO + 8'(fpart >> FRAC_BITS));
        fpart = fpart & ((64'd1 << FRAC_BITS) - 64'd1);
      end
    end
    push_text(chars);
  endfunction

  // Random float patterns, weighted toward magnitudes that format, with integers,
  // tiny values, subnormals, zeros and error patterns mixed in.
  function automatic logic [31:0] random_float();
    logic [31:0] v;
    int unsigned pick;
    int unsigned bexp;
    v = $urandom;
    pick = $urandom_range(99);
    if (pick < 38) begin
      v[30:23] = 8'($urandom_range(157, 110));
    end else if (pick < 55) begin
      v[30:23] = 8'($urandom_range(157, 127));
    end else if (pick < 65) begin
      // Whole numbers: clear the significand bits that lie below the binary point.
      bexp = $urandom_range(UNIT_EXP, 127);
      v[30:23] = 8'(bexp);
      v[22:0] = v[22:0] & (23'h7F_FFFF << (UNIT_EXP - bexp));
    end else if (pick < 72) begin
      v[30:23] = 8'($urandom_range(109, 1));
    end else if (pick < 78) begin
      v[30:23] = 8'd0;
    end else if (pick < 85) begin
      v[30:23] = 8'($urandom_range(255, 158));
    end else if (pick < 89) begin
      v[30:0] = '0;
    end
    return v;
  endfunction

  // Offers one transaction on the input side and records what it must produce.
  task automatic send_item(input logic [31:0] value_bits, input logic [3:0] precision,
                           input row_check_t check, input logic [8*TEXT_CHARS-1:0] text);
    logic [7:0] chars[$];
    while ($urandom_range(99) < in_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_value_bits <= value_bits;
    in_precision  <= precision;
    do @(posedge clk); while (in_ready !== 1'b1);
    case (check)
      TYPED_ERROR: begin
        pending_chars.push_back('{CHAR_NONE, 1'b1, 1'b1});
      end
      TYPED_TEXT: begin
        for (int k = TEXT_CHARS - 1; k >= 0; k--) begin
          if (text[k*8 +: 8] != 8'h00) begin
            chars.push_back(text[k*8 +: 8]);
          end
        end
        push_text(chars);
      end
      default: begin
        format_value(value_bits, precision);
      end
    endcase
  endtask

  // The output side draws out_ready each cycle. On request it holds off for a long,
  // counted stretch so that the block fills and has to refuse input.
  initial begin : receiver
    int hold_left;
    hold_left = 0;
    forever begin
      if (hold_request) begin
        hold_request = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
        out_ready <= 1'b0;
        hold_left--;
      end else begin
        out_ready <= ($urandom_range(99) >= out_idle_pct);
      end
      @(posedge clk);
    end
  end

  // Every output transaction is checked against the oldest expected character.
  always @(posedge clk) begin
    text_char_t want;
    if (rst_n && out_valid === 1'b1 && out_ready) begin
      if (pending_chars.size() == 0) begin
        fail_count++;
        $display("%0t: unexpected character %02h last %b error %b", $time,
                 out_character, out_last_char, out_error_flag);
      end else begin
        want = pending_chars.pop_front();
        if (out_character !== want.character) begin
          fail_count++;
          $display("%0t: character expected %02h actual %02h", $time,
                   want.character, out_character);
        end
        if (out_last_char !== want.last_char) begin
          fail_count++;
          $display("%0t: last_char expected %b actual %b", $time,
                   want.last_char, out_last_char);
        end
        if (out_error_flag !== want.error_flag) begin
          fail_count++;
          $display("%0t: error_flag expected %b actual %b", $time,
                   want.error_flag, out_error_flag);
        end
      end
    end
  end

  initial begin : stimulus
    logic [3:0] precision;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    foreach (dir_rows[i]) begin
      send_item(dir_rows[i].value_bits, dir_rows[i].precision, dir_rows[i].check,
                dir_rows[i].text);
    end

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      // A long stretch where neither side ever idles.
      if (n == 100) begin
        in_idle_pct = 0;
        out_idle_pct = 0;
      end
      if (n == 160) begin
        in_idle_pct = IDLE_PCT;
        out_idle_pct = IDLE_PCT;
      end
      // The receiver holds off while the sender keeps offering back to back.
      if (n == 200) begin
        in_idle_pct = 0;
        hold_request = 1'b1;
      end
      if (n == 220) begin
        in_idle_pct = IDLE_PCT;
      end
      // Most precisions stay within the limit; the rest reach every 4-bit value.
      precision = ($urandom_range(99) < 70) ? 4'($urandom_range(PRECISION_LIMIT))
                                             : 4'($urandom_range(15));
      send_item(random_float(), precision, FROM_MODEL, '0);
    end
    in_valid <= 1'b0;

    // Let the last text drain, then watch a little longer for stray transactions.
    while (pending_chars.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin : watchdog
    #400_000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

// ===== files.f =====
src/fdt_pkg.sv
src/fdt_unpack.sv
src/fdt_digit_unit.sv
src/float_to_decimal_text.sv
test/float_to_decimal_text_tb.sv
